// ===== hw/rtl/psl_pkg.sv =====
// Shared types and constants for the stream locator.
package psl_pkg;

  // Offset and position widths
  localparam int unsigned OFF_W = 24;
  localparam int unsigned POS_W = 25;
  localparam int unsigned CFG_W = 25;
  localparam int unsigned SUM_W = 26;

  // Positions at or beyond this limit are not scanned
  localparam logic [POS_W-1:0] MAX_BUFFER_BYTES = 25'h100_0000;

  // Keyword patterns, oldest byte in the high bits
  localparam logic [47:0] KW_STREAM   = 48'h7374_7265_616D;
  localparam logic [63:0] KW_NDSTREAM = 64'h6E64_7374_7265_616D;
  localparam logic [7:0]  CH_E        = 8'h65;
  localparam logic [15:0] CRLF        = 16'h0D0A;

  // Distances in bytes
  localparam logic [OFF_W-1:0] STREAM_BACK   = 24'd5;
  localparam logic [OFF_W-1:0] END_BACK      = 24'd8;
  localparam logic [POS_W-1:0] STREAM_MIN    = 25'd5;
  localparam logic [POS_W-1:0] END_MIN       = 25'd8;
  localparam logic [POS_W-1:0] BODY_SKIP     = 25'd7;
  localparam logic [POS_W-1:0] BODY_SKIP_NL  = 25'd8;
  localparam logic [POS_W-1:0] RESUME_STEP   = 25'd10;
  localparam logic [SUM_W-1:0] SEARCH_MARGIN = 26'd15;

  // Scan phase
  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_OPEN   = 2'd1,
    PH_STOP   = 2'd2
  } phase_t;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [OFF_W-1:0] tag_offset;
    logic [OFF_W-1:0] body_start_offset;
    logic [OFF_W-1:0] end_tag_offset;
  } out_word_t;

endpackage

// ===== hw/rtl/psl_in_reg.sv =====
// Input register stage for the stream locator.
module psl_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  psl_pkg::in_word_t in_data,
  input  logic             advance,
  output logic             word_valid,
  output psl_pkg::in_word_t word
);
  import psl_pkg::*;

  logic word_valid_next;

  // Take a new word when the register is empty or the held one moves on this cycle
  assign in_ready = !word_valid || advance;

  always_comb begin
    word_valid_next = word_valid;
    if (in_valid && in_ready) begin
      word_valid_next = 1'b1;
    end else if (advance) begin
      word_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else begin
      word_valid <= word_valid_next;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= in_data;
    end
  end

endmodule

// ===== hw/rtl/psl_scan_core.sv =====
// Keyword matcher, scan state and result register for the stream locator.
module psl_scan_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [psl_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          word_valid,
  input  psl_pkg::in_word_t             word,
  output logic                          advance,
  output logic                          out_valid,
  input  logic                          out_ready,
  output psl_pkg::out_word_t            out_data
);
  import psl_pkg::*;

  // Registers
  logic [CFG_W-1:0] buffer_size;
  logic [POS_W-1:0] byte_position;
  logic [63:0]      recent_bytes;
  phase_t           scan_phase;
  logic [OFF_W-1:0] open_tag_offset;
  logic [POS_W-1:0] open_body_start;
  logic [POS_W-1:0] resume_position;

  logic [POS_W-1:0] byte_position_next;
  logic [63:0]      recent_bytes_next;
  phase_t           scan_phase_next;
  logic [OFF_W-1:0] open_tag_offset_next;
  logic [POS_W-1:0] open_body_start_next;
  logic [POS_W-1:0] resume_position_next;

  // Match terms
  logic             fire;
  logic             in_range;
  logic [7:0]       oldest;
  logic             is_stream;
  logic             is_end;
  logic [OFF_W-1:0] kw_at;
  logic [OFF_W-1:0] end_tag;
  logic [POS_W-1:0] tag_wide;
  logic [POS_W-1:0] body_start_eff;
  logic             hit;
  out_word_t        result;

  // Move on when the result register is free or being emptied
  assign advance = !out_valid || out_ready;
  assign fire    = word_valid && advance;

  assign in_range          = byte_position < MAX_BUFFER_BYTES;
  assign oldest            = recent_bytes[63:56];
  assign recent_bytes_next = {recent_bytes[55:0], word.data_byte};
  assign is_stream = (byte_position >= STREAM_MIN) && (recent_bytes_next[47:0] == KW_STREAM);
  assign is_end    = (byte_position >= END_MIN) && (recent_bytes_next == KW_NDSTREAM)
                     && (oldest == CH_E);
  assign kw_at      = byte_position[OFF_W-1:0] - STREAM_BACK;
  assign end_tag    = byte_position[OFF_W-1:0] - END_BACK;
  assign tag_wide   = {1'b0, open_tag_offset};

  // Settle body start once the two bytes after the keyword are in
  always_comb begin
    body_start_eff = open_body_start;
    if (scan_phase == PH_OPEN && byte_position == tag_wide + BODY_SKIP
        && recent_bytes_next[15:0] == CRLF) begin
      body_start_eff = tag_wide + BODY_SKIP_NL;
    end
  end

  // Next scan state and result
  always_comb begin
    byte_position_next   = byte_position;
    scan_phase_next      = scan_phase;
    open_tag_offset_next = open_tag_offset;
    open_body_start_next = open_body_start;
    resume_position_next = resume_position;
    hit                  = 1'b0;
    result.tag_offset        = open_tag_offset;
    result.body_start_offset = body_start_eff[OFF_W-1:0];
    result.end_tag_offset    = end_tag;

    if (in_range) begin
      byte_position_next   = byte_position + 1'b1;
      open_body_start_next = body_start_eff;
      unique case (scan_phase)
        PH_SEARCH: begin
          if (is_stream && {1'b0, kw_at} >= resume_position
              && ({1'b0, resume_position} + SEARCH_MARGIN) < {1'b0, buffer_size}) begin
            open_tag_offset_next = kw_at;
            open_body_start_next = {1'b0, kw_at} + BODY_SKIP;
            scan_phase_next      = PH_OPEN;
          end
        end
        PH_OPEN: begin
          if (is_end && {1'b0, end_tag} >= body_start_eff) begin
            hit                  = 1'b1;
            resume_position_next = {1'b0, end_tag} + RESUME_STEP;
            scan_phase_next      = PH_SEARCH;
          end else if (is_stream && {1'b0, kw_at} >= body_start_eff) begin
            if (({2'b0, kw_at} + SEARCH_MARGIN) < {1'b0, buffer_size}) begin
              open_tag_offset_next = kw_at;
              open_body_start_next = {1'b0, kw_at} + BODY_SKIP;
              scan_phase_next      = PH_OPEN;
            end else begin
              scan_phase_next = PH_STOP;
            end
          end
        end
        PH_STOP: begin
          scan_phase_next = PH_STOP;
        end
        default: begin
          scan_phase_next = PH_SEARCH;
        end
      endcase
    end

    // Drop all scan state after the final byte
    if (word.last_byte) begin
      byte_position_next   = '0;
      scan_phase_next      = PH_SEARCH;
      open_tag_offset_next = '0;
      open_body_start_next = '0;
      resume_position_next = '0;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= '0;
    end else if (cfg_valid) begin
      buffer_size <= cfg_data;
    end
  end

  // Scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      recent_bytes    <= '0;
      scan_phase      <= PH_SEARCH;
      open_tag_offset <= '0;
      open_body_start <= '0;
      resume_position <= '0;
    end else if (fire) begin
      byte_position   <= byte_position_next;
      scan_phase      <= scan_phase_next;
      open_tag_offset <= open_tag_offset_next;
      open_body_start <= open_body_start_next;
      resume_position <= resume_position_next;
      if (word.last_byte) begin
        recent_bytes <= '0;
      end else if (in_range) begin
        recent_bytes <= recent_bytes_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hit) begin
      out_data <= result;
    end
  end

endmodule

// ===== hw/rtl/pdf_stream_locator.sv =====
// Top level of the stream locator.
//
// Usage:
//   Bytes of one buffer enter on the in channel (in_valid/in_ready), one word
//   per byte, with last_byte set on the final byte; after that byte all scan
//   state clears and the next word starts a new buffer at offset 0.
//   Each located stream body leaves on the out channel (out_valid/out_ready)
//   as one word: keyword offset, body start offset and end keyword offset.
//   buffer_size is written on the cfg channel (cfg_valid/cfg_ready, always
//   ready) while no byte is in flight.
// Throughput and pipeline:
//   One byte is taken every cycle while no result waits on out_ready: an
//   input register feeds the matcher and the state update, which fills a
//   result register; the byte that completes the end keyword passes both.
// Reset:
//   rst (synchronous) clears the scan state, buffer_size and both valids.
// Stalls:
//   While a result waits on out_ready, the input register accepts one more
//   byte only if it is empty; further bytes wait until the result is taken.
module pdf_stream_locator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [psl_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  psl_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output psl_pkg::out_word_t        out_data
);
  import psl_pkg::*;

  logic     advance;
  logic     word_valid;
  in_word_t word;

  assign cfg_ready = 1'b1;

  psl_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  psl_scan_core u_scan_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .word_valid (word_valid),
    .word       (word),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== hw/rtl/psl_checker.sv =====
// Port-level checks for the stream locator, bound to the top level.
module psl_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input psl_pkg::out_word_t  out_data
);
  import psl_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // No result in the cycle after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A new result follows an accepted byte through the input and result registers
  a_rise_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an accepted byte");

  // Offsets are ordered when no wrap can occur
  a_offset_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.tag_offset < 24'hFFFFF0 |->
      (({1'b0, out_data.body_start_offset} == {1'b0, out_data.tag_offset} + 25'd7) ||
       ({1'b0, out_data.body_start_offset} == {1'b0, out_data.tag_offset} + 25'd8)) &&
      (out_data.end_tag_offset >= out_data.body_start_offset))
    else $error("result offsets out of order");

endmodule

bind pdf_stream_locator psl_checker u_psl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/pdf_stream_locator_tb.sv =====
// Self-checking testbench for pdf_stream_locator with a queue-fed driver and a result monitor.
module pdf_stream_locator_tb;
  import psl_pkg::*;

  localparam int unsigned HALF_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned TARGET_BYTES  = 1550;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam logic [CFG_W-1:0] SIZE_MAX = 25'd16777216;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_word_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_word_t          out_data;

  // Scanner image kept in step with the accepted words
  logic [CFG_W-1:0]   size_cfg;
  logic [POS_W-1:0]   scan_pos;
  logic [63:0]        window;
  phase_t             phase;
  logic [OFF_W-1:0]   tag_at;
  logic [POS_W-1:0]   body_at;
  logic [POS_W-1:0]   resume_at;

  in_word_t           byte_feed_q[$];
  out_word_t          located_q[$];
  logic [7:0]         frame_q[$];

  int unsigned        mismatches = 0;
  int unsigned        bytes_pushed = 0;
  int unsigned        cycles = 0;
  int unsigned        burst_left = 0;
  int unsigned        gap_left = 0;
  rx_mode_t           rx_mode = RX_FREE;
  int unsigned        rx_mode_left = 0;
  int unsigned        rx_tick = 0;

  pdf_stream_locator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Bail out if the run hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic clear_scan();
    scan_pos  = '0;
    window    = '0;
    phase     = PH_SEARCH;
    tag_at    = '0;
    body_at   = '0;
    resume_at = '0;
  endtask

  task automatic open_body_at(input int unsigned kw);
    tag_at  = kw[OFF_W-1:0];
    body_at = POS_W'(kw + 7);
    phase   = PH_OPEN;
  endtask

  // Advance the scanner image by one word and queue any located body
  task automatic scan_byte(input in_word_t w);
    logic [7:0]  shifted_out;
    bit          hit_stream;
    bit          hit_end;
    int unsigned p;
    int unsigned kw;
    int unsigned end_kw;
    out_word_t   found;
    if (scan_pos < MAX_BUFFER_BYTES) begin
      p           = 32'(scan_pos);
      shifted_out = window[63:56];
      window      = {window[55:0], w.data_byte};
      hit_stream  = (p >= 5) && (window[47:0] == KW_STREAM);
      hit_end     = (p >= 8) && (window == KW_NDSTREAM) && (shifted_out == CH_E);
      kw          = p - 5;
      end_kw      = p - 8;
      // Settle the body start once the two bytes after the keyword are in
      if (phase == PH_OPEN && p == tag_at + 7 && window[15:0] == CRLF) begin
        body_at = POS_W'(tag_at + 8);
      end
      case (phase)
        PH_SEARCH: begin
          if (hit_stream && kw >= resume_at && resume_at + 15 < size_cfg) begin
            open_body_at(kw);
          end
        end
        PH_OPEN: begin
          if (hit_end && end_kw >= body_at) begin
            found.tag_offset        = tag_at;
            found.body_start_offset = body_at[OFF_W-1:0];
            found.end_tag_offset    = end_kw[OFF_W-1:0];
            located_q.insert(located_q.size(), found);
            resume_at = POS_W'(end_kw + 10);
            phase     = PH_SEARCH;
          end else if (hit_stream && kw >= body_at) begin
            if (kw + 15 < size_cfg) begin
              open_body_at(kw);
            end else begin
              phase = PH_STOP;
            end
          end
        end
        default: ;
      endcase
      scan_pos = POS_W'(p + 1);
    end
    if (w.last_byte) begin
      clear_scan();
    end
  endtask

  // Driver: bursts of words from the feed queue with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      size_cfg = '0;
      clear_scan();
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_cfg = cfg_data;
      end
      if (in_valid && in_ready) begin
        scan_byte(in_data);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_feed_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= byte_feed_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [OFF_W-1:0] want,
                                      input logic [OFF_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Monitor: check each result word and stall on a pattern of its own
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (located_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: expected nothing, actual %0d/%0d/%0d",
                   $time, out_data.tag_offset, out_data.body_start_offset,
                   out_data.end_tag_offset);
        end else begin
          want = located_q.pop_front();
          check_field("tag_offset", want.tag_offset, out_data.tag_offset);
          check_field("body_start_offset", want.body_start_offset,
                      out_data.body_start_offset);
          check_field("end_tag_offset", want.end_tag_offset, out_data.end_tag_offset);
        end
      end
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(40, 300);
      end else begin
        rx_mode_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_FREE:  out_ready <= 1'b1;
        RX_LIGHT: out_ready <= ($urandom_range(0, 9) < 7);
        RX_HEAVY: out_ready <= ($urandom_range(0, 9) < 3);
        default:  out_ready <= (rx_tick % 5 == 0);
      endcase
    end
  end

  // Wait until no word is queued, none is offered and no result is owed
  task automatic wait_drained();
    do @(negedge clk);
    while (byte_feed_q.size() != 0 || in_valid || located_q.size() != 0);
  endtask

  task automatic write_buffer_size(input logic [CFG_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i]);
    end
  endtask

  // Mix of raw bytes and keyword letters so partial matches show up
  task automatic add_noise(input int unsigned n);
    string       letters;
    int unsigned k;
    letters = "streamnd";
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if ($urandom_range(0, 1) == 0) add_byte(8'($urandom_range(0, 255)));
      else if (k < 8) add_byte(letters[k]);
      else if (k == 8) add_byte(CRLF[15:8]);
      else add_byte(CRLF[7:0]);
    end
  endtask

  task automatic add_terminator();
    case ($urandom_range(0, 4))
      0: begin
        add_byte(CRLF[15:8]);
        add_byte(CRLF[7:0]);
      end
      1: add_byte(8'($urandom_range(0, 255)));
      2: add_byte(CRLF[15:8]);
      3: add_byte(CRLF[7:0]);
      default: ;
    endcase
  endtask

  task automatic add_segment();
    case ($urandom_range(0, 9))
      // complete body
      0, 1, 2, 3: begin
        add_text("stream");
        add_terminator();
        add_noise($urandom_range(0, 8));
        add_text("endstream");
      end
      // second bare keyword before the end keyword
      4: begin
        add_text("stream");
        add_terminator();
        add_noise($urandom_range(0, 4));
        add_text("stream");
        add_terminator();
        add_noise($urandom_range(0, 4));
        add_text("endstream");
      end
      // end keyword right after the keyword, just before the body start
      5: begin
        add_text("streamendstream");
        add_noise($urandom_range(0, 4));
        if ($urandom_range(0, 1) == 0) add_text("endstream");
      end
      // body never closed
      6: begin
        add_text("stream");
        add_terminator();
        add_noise($urandom_range(0, 6));
      end
      // broken keywords
      7: begin
        case ($urandom_range(0, 2))
          0: add_text("strea");
          1: add_text("endstrea");
          default: add_text("endstreax");
        endcase
      end
      default: add_noise($urandom_range(1, 12));
    endcase
  endtask

  task automatic build_frame();
    if ($urandom_range(0, 7) == 0) begin
      add_byte(8'($urandom_range(0, 255)));
    end else begin
      add_noise($urandom_range(0, 6));
      repeat ($urandom_range(1, 5)) add_segment();
      add_noise($urandom_range(0, 6));
    end
  endtask

  // Queue the frame as words, last one marked; optionally hold off midway
  task automatic send_frame(input bit pause_midway);
    int unsigned cut;
    int unsigned n;
    in_word_t    w;
    n   = frame_q.size();
    cut = (pause_midway && n >= 2) ? $urandom_range(1, n - 1) : n;
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      if (i == cut) wait_drained();
      w.data_byte = frame_q[i];
      w.last_byte = (i == n - 1);
      byte_feed_q.insert(byte_feed_q.size(), w);
    end
    bytes_pushed += n;
    frame_q.delete();
  endtask

  initial begin : stimulus
    int unsigned      len;
    int unsigned      frames;
    logic [CFG_W-1:0] size_pick;
    bit               first_random;
    first_random = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: smallest body at full size, then one-byte buffers at the extremes
    write_buffer_size(SIZE_MAX);
    add_text("stream");
    add_byte(CRLF[15:8]);
    add_byte(CRLF[7:0]);
    add_text("endstream");
    send_frame(1'b0);
    add_byte(8'hFF);
    send_frame(1'b0);
    write_buffer_size('0);
    add_byte(8'h00);
    send_frame(1'b0);

    // Random: one size setting per group of frames
    while (bytes_pushed < TARGET_BYTES) begin
      build_frame();
      len = frame_q.size();
      case ($urandom_range(0, 9))
        0:       size_pick = '0;
        1:       size_pick = SIZE_MAX;
        2:       size_pick = CFG_W'($urandom_range(0, 16777216));
        3:       size_pick = CFG_W'($urandom_range(0, 64));
        4, 5:    size_pick = CFG_W'((len > 20) ? len - $urandom_range(0, 20) : len);
        default: size_pick = CFG_W'(len + $urandom_range(0, 16));
      endcase
      write_buffer_size(size_pick);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames && bytes_pushed < TARGET_BYTES; f++) begin
        if (f != 0) build_frame();
        send_frame(first_random || $urandom_range(0, 5) == 0);
        first_random = 1'b0;
      end
    end

    wait_drained();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
